// ----- rtl/rlpo_pkg.sv -----
// Shared types, codes and widths for the ring list play-order sequencer.
package rlpo_pkg;

  // Fixed field widths
  localparam int IDX_W   = 5;   // play index, add slot
  localparam int CNT_W   = 6;   // entry count, 0..32
  localparam int STEP_W  = 7;   // signed relative step
  localparam int RND_W   = 16;  // random value / modulo dividend
  localparam int ITER_W  = $clog2(RND_W);
  localparam int WRAP_SH = 6;   // bias of 64*count keeps wrap dividends positive

  localparam int DEF_CAPACITY = 16;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_SEQ     = 3'd1,
    REQ_REL     = 3'd2,
    REQ_JUMP    = 3'd3,
    REQ_RESTART = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_t;

  // Play order register codes
  typedef enum logic [1:0] {
    ORDER_FWD  = 2'd0,
    ORDER_BWD  = 2'd1,
    ORDER_RAND = 2'd2,
    ORDER_SHUF = 2'd3
  } order_t;

  // Operand selection for the modulo unit
  typedef enum logic [2:0] {
    MSEL_FWD     = 3'd0,
    MSEL_BWD     = 3'd1,
    MSEL_REL     = 3'd2,
    MSEL_RAND    = 3'd3,
    MSEL_SHUF    = 3'd4,
    MSEL_RESTART = 3'd5
  } msel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  mod_start;
    msel_t mod_sel;
    logic  scan_clr;
    logic  scan_count;
    logic  scan_find;
    logic  commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] req;
    order_t     play_order;
    logic       first_pending;
    logic       multi;
    logic       mod_done;
    logic       scan_last;
    logic       scan_hit;
    logic       cnt_zero;
  } dp_stat_t;

endpackage

// ----- rtl/ring_list_play_order_sequencer.sv -----
// Top level of the ring list play-order sequencer.
// Usage:
//   Input beat: drive in_* with start high; it is taken at an edge where busy
//   is low. busy stays high until the result is committed.
//   Result beat: out_valid is high for exactly one cycle with out_* holding the
//   index, count and next add slot after the request. The receiver cannot stall.
//   Config: cfg_wr_en with cfg_wr_data writes the play order; write while idle.
//   A restart request then sets up the start index and shuffle mask.
// Sequencing (a new request is taken only after the last one is committed):
//   Add, jump, clear, ordered restart and steps that do not move go straight to
//   commit. Wrapped, random and restart steps in random or shuffle order wait on
//   the shared modulo unit, which retires one dividend bit per cycle.
//   A shuffle step walks the unplayed mask one entry per cycle to count, then
//   runs the modulo unit, then walks the mask again to find the picked entry.
// Reset: synchronous, active low; list empty, first-play flag set, mask clear,
//   order forward.
module ring_list_play_order_sequencer import rlpo_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_req_type,
  input  logic [STEP_W-1:0] in_step_amount,
  input  logic [IDX_W-1:0]  in_target_index,
  input  logic [RND_W-1:0]  in_rand_value,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_play_index,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_has_entry,
  output logic [IDX_W-1:0]  out_next_add_slot,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlpo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  rlpo_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_step_amount  (in_step_amount),
    .in_target_index (in_target_index),
    .in_rand_value   (in_rand_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .play_index      (out_play_index),
    .entry_count     (out_entry_count),
    .has_entry       (out_has_entry),
    .next_add_slot   (out_next_add_slot)
  );

endmodule

// ----- rtl/rlpo_mod_unit.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
module rlpo_mod_unit import rlpo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] rem
);

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(RND_W - 1);

  logic              run_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [RND_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;

  // Partial remainder stays below the divisor (at most 32), so its top bit is free
  logic [CNT_W-1:0] trial;
  logic [CNT_W-1:0] diff;
  logic             ge;

  assign trial = {rem_r[CNT_W-2:0], quo_r[RND_W-1]};
  assign diff  = trial - div_r;
  assign ge    = (trial >= div_r);

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        iter_r <= '0;
      end else if (run_r) begin
        iter_r <= iter_r + ITER_W'(1);
        if (iter_r == ITER_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[RND_W-2:0], 1'b0};
      rem_r <= ge ? diff : trial;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/rlpo_datapath.sv -----
// List state registers, shuffle mask scan, operand select and commit logic.
module rlpo_datapath import rlpo_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [2:0]        in_req_type,
  input  logic [STEP_W-1:0] in_step_amount,
  input  logic [IDX_W-1:0]  in_target_index,
  input  logic [RND_W-1:0]  in_rand_value,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  output logic [IDX_W-1:0]  play_index,
  output logic [CNT_W-1:0]  entry_count,
  output logic              has_entry,
  output logic [IDX_W-1:0]  next_add_slot
);

  localparam int                SCAN_W   = $clog2(CAPACITY);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0]  CAP_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CAPACITY-1:0] MASK_ONE = CAPACITY'(1);

  // Architectural state
  order_t              play_order_r;
  logic [IDX_W-1:0]    add_pos_r,  add_pos_nxt;
  logic [CNT_W-1:0]    count_r,    count_nxt;
  logic [IDX_W-1:0]    cur_r,      cur_nxt;
  logic                fp_r,       fp_nxt;
  logic [CAPACITY-1:0] mask_r,     mask_nxt;

  // Latched item fields
  logic [2:0]          req_r;
  logic [STEP_W-1:0]   step_r;
  logic [IDX_W-1:0]    target_r;
  logic [RND_W-1:0]    rnd_r;

  // Working registers
  logic [IDX_W-1:0]    cand_r;
  logic [CNT_W-1:0]    pick_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SCAN_W-1:0]   scan_idx_r;
  msel_t               msel_r;

  logic                multi;
  logic                live;
  logic [CAPACITY-1:0] fill_mask;
  logic [STEP_W-1:0]   wrap_delta;
  logic [RND_W-1:0]    wrap_sum;
  logic [RND_W-1:0]    mod_dividend;
  logic [CNT_W-1:0]    mod_divisor;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  assign multi = (count_r > CNT_W'(1));
  assign live  = mask_r[scan_idx_r] && (CNT_W'(scan_idx_r) < count_r);

  // Mask of all indices below the entry count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      fill_mask[i] = (CNT_W'(i) < count_r);
    end
  end

  // Wrap dividend: current index plus offset, biased by 64 times the count
  always_comb begin
    case (cmd.mod_sel)
      MSEL_FWD: wrap_delta = STEP_W'(1);
      MSEL_BWD: wrap_delta = {STEP_W{1'b1}};
      default:  wrap_delta = step_r;
    endcase
  end

  assign wrap_sum = RND_W'(cur_r)
                  + {{(RND_W-STEP_W){wrap_delta[STEP_W-1]}}, wrap_delta}
                  + RND_W'({count_r, WRAP_SH'(0)});

  // Modulo operand select
  always_comb begin
    case (cmd.mod_sel)
      MSEL_FWD, MSEL_BWD, MSEL_REL: begin
        mod_dividend = wrap_sum;
        mod_divisor  = count_r;
      end
      MSEL_RAND: begin
        mod_dividend = rnd_r;
        mod_divisor  = count_r - CNT_W'(1);
      end
      MSEL_SHUF: begin
        mod_dividend = rnd_r;
        mod_divisor  = cnt_r;
      end
      default: begin
        mod_dividend = rnd_r;
        mod_divisor  = count_r;
      end
    endcase
  end

  rlpo_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Item fields latch on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      step_r   <= in_step_amount;
      target_r <= in_target_index;
      rnd_r    <= in_rand_value;
    end
  end

  // Candidate index: current index by default, replaced by modulo or scan result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r <= cur_r;
    end else if (mod_done) begin
      case (msel_r)
        MSEL_RAND: cand_r <= (mod_rem >= CNT_W'(cur_r)) ? IDX_W'(mod_rem + CNT_W'(1))
                                                        : mod_rem[IDX_W-1:0];
        MSEL_SHUF: pick_r <= mod_rem;
        default:   cand_r <= mod_rem[IDX_W-1:0];
      endcase
    end else if (cmd.scan_find && live && (cnt_r == pick_r)) begin
      cand_r <= IDX_W'(scan_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      msel_r <= cmd.mod_sel;
    end
  end

  // Mask scan: count unplayed entries, then find the picked one
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx_r <= '0;
      cnt_r      <= '0;
    end else if (cmd.scan_count || cmd.scan_find) begin
      scan_idx_r <= scan_idx_r + SCAN_W'(1);
      if (live) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Commit values per request
  always_comb begin
    add_pos_nxt = add_pos_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    fp_nxt      = fp_r;
    mask_nxt    = mask_r;
    case (req_r)
      REQ_ADD: begin
        cur_nxt     = add_pos_r;
        add_pos_nxt = (add_pos_r == CAP_LAST) ? '0 : add_pos_r + IDX_W'(1);
        if (count_r < CAP_CNT) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_SEQ: begin
        cur_nxt  = cand_r;
        mask_nxt = mask_r & ~(MASK_ONE << cand_r);
        if (count_r != '0) fp_nxt = 1'b0;
      end
      REQ_REL: begin
        cur_nxt = (!fp_r && !multi) ? '0 : cand_r;
        if (count_r != '0) fp_nxt = 1'b0;
      end
      REQ_JUMP: begin
        if (!multi) begin
          cur_nxt = '0;
        end else if (CNT_W'(target_r) >= count_r) begin
          cur_nxt = IDX_W'(count_r - CNT_W'(1));
        end else begin
          cur_nxt = target_r;
        end
        if (count_r != '0) fp_nxt = 1'b0;
      end
      REQ_RESTART: begin
        fp_nxt = 1'b1;
        if (!multi) begin
          cur_nxt = '0;
        end else begin
          case (play_order_r)
            ORDER_FWD: cur_nxt = (count_r == CAP_CNT) ? add_pos_r : '0;
            ORDER_BWD: cur_nxt = (add_pos_r != '0) ? add_pos_r - IDX_W'(1) : CAP_LAST;
            default: begin
              cur_nxt  = cand_r;
              mask_nxt = fill_mask;
            end
          endcase
        end
      end
      REQ_CLEAR: begin
        add_pos_nxt = '0;
        count_nxt   = '0;
        cur_nxt     = '0;
        fp_nxt      = 1'b1;
        mask_nxt    = '0;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_order_r <= ORDER_FWD;
      add_pos_r    <= '0;
      count_r      <= '0;
      cur_r        <= '0;
      fp_r         <= 1'b1;
      mask_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        play_order_r <= order_t'(cfg_wr_data);
      end
      if (cmd.commit) begin
        add_pos_r <= add_pos_nxt;
        count_r   <= count_nxt;
        cur_r     <= cur_nxt;
        fp_r      <= fp_nxt;
        mask_r    <= mask_nxt;
      end
    end
  end

  // Status
  always_comb begin
    stat.req           = req_r;
    stat.play_order    = play_order_r;
    stat.first_pending = fp_r;
    stat.multi         = multi;
    stat.mod_done      = mod_done;
    stat.scan_last     = (scan_idx_r == SCAN_END);
    stat.scan_hit      = live && (cnt_r == pick_r);
    stat.cnt_zero      = (cnt_r == '0);
  end

  // Results are the state after commit
  assign play_index    = cur_r;
  assign entry_count   = count_r;
  assign has_entry     = (count_r != '0);
  assign next_add_slot = add_pos_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_add_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(add_pos_r) < CAP_CNT)
    else $error("add position outside ring");

endmodule

// ----- rtl/rlpo_ctrl.sv -----
// Controller state machine: sequences load, modulo, mask scan and commit.
module rlpo_ctrl import rlpo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_COUNT,
    ST_COUNT_END,
    ST_MODWAIT,
    ST_FIND,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   shuf_step;

  assign shuf_step = (stat.req == REQ_SEQ) && (stat.play_order == ORDER_SHUF);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_COMMIT;
        case (stat.req)
          REQ_SEQ: begin
            if (!stat.first_pending && stat.multi) begin
              state_nxt = ST_MODWAIT;
              cmd.mod_start = 1'b1;
              case (stat.play_order)
                ORDER_FWD:  cmd.mod_sel = MSEL_FWD;
                ORDER_BWD:  cmd.mod_sel = MSEL_BWD;
                ORDER_RAND: cmd.mod_sel = MSEL_RAND;
                default: begin
                  cmd.mod_start = 1'b0;
                  cmd.scan_clr  = 1'b1;
                  state_nxt     = ST_COUNT;
                end
              endcase
            end
          end
          REQ_REL: begin
            if (!stat.first_pending && stat.multi) begin
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = MSEL_REL;
              state_nxt     = ST_MODWAIT;
            end
          end
          REQ_RESTART: begin
            if (stat.multi && (stat.play_order == ORDER_RAND ||
                               stat.play_order == ORDER_SHUF)) begin
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = MSEL_RESTART;
              state_nxt     = ST_MODWAIT;
            end
          end
          default: ;
        endcase
      end
      ST_COUNT: begin
        cmd.scan_count = 1'b1;
        if (stat.scan_last) state_nxt = ST_COUNT_END;
      end
      ST_COUNT_END: begin
        // nothing left unplayed: keep the current index
        if (stat.cnt_zero) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_SHUF;
          cmd.scan_clr  = 1'b1;
          state_nxt     = ST_MODWAIT;
        end
      end
      ST_MODWAIT: begin
        if (stat.mod_done) state_nxt = shuf_step ? ST_FIND : ST_COMMIT;
      end
      ST_FIND: begin
        cmd.scan_find = 1'b1;
        if (stat.scan_hit) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_COMMIT);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_find_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && stat.scan_last) |-> stat.scan_hit)
    else $error("shuffle pick not found in mask");

endmodule
